// ----- hdl/cvfs_pkg.sv -----
// ----------------------------------------------------------------------------
// cvfs_pkg
// Shared types and constants for the cell voltage frame statistics block.
// ----------------------------------------------------------------------------
package cvfs_pkg;

  // Field widths
  localparam int unsigned BYTE_W    = 8;
  localparam int unsigned RAW_W     = 16;
  localparam int unsigned POS_W     = 6;
  localparam int unsigned DEV_W     = 6;
  localparam int unsigned IDX_W     = 4;
  localparam int unsigned CELLS_W   = 5;
  localparam int unsigned NDEV_W    = 7;
  localparam int unsigned VOLT_W    = 31;
  localparam int unsigned TOTAL_W   = 41;
  localparam int unsigned CFG_IDX_W = 1;
  localparam int unsigned CFG_DAT_W = 7;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_CELLS_PER_DEVICE = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_NUM_DEVICES      = 1'b1;

  // Register reset values
  localparam logic [CELLS_W-1:0] CELLS_RESET = 5'd16;
  localparam logic [NDEV_W-1:0]  NDEV_RESET  = 7'd1;

  // Frame layout
  localparam logic [CELLS_W-1:0] CELLS_MIN      = 5'd6;
  localparam logic [NDEV_W-1:0]  NDEV_MIN       = 7'd1;
  localparam logic [POS_W-1:0]   HEADER_BYTES   = 6'd4;
  localparam logic [POS_W-1:0]   FRAME_OVERHEAD = 6'd6;

  // raw * 190.73 uV, kept exact in units of 0.01 uV
  localparam logic [14:0] VOLT_SCALE = 15'd19073;

  // Token from the frame parser: a finished sample and/or a statistics clear
  typedef struct packed {
    logic             sample;
    logic             clear;
    logic [DEV_W-1:0] dev;
    logic [IDX_W-1:0] idx;
    logic             last;
    logic [RAW_W-1:0] raw;
  } cvfs_tok_t;

  // Token after scaling
  typedef struct packed {
    logic              sample;
    logic              clear;
    logic [DEV_W-1:0]  dev;
    logic [IDX_W-1:0]  idx;
    logic              last;
    logic [VOLT_W-1:0] volt;
  } cvfs_scl_t;

endpackage

// ----- hdl/cvfs_parser.sv -----
// ----------------------------------------------------------------------------
// cvfs_parser
// Holds the configuration registers, walks the response frames byte by byte
// and issues a token for each completed sample or statistics clear.
// ----------------------------------------------------------------------------
module cvfs_parser #(
  parameter int unsigned MAX_CELLS   = 16,
  parameter int unsigned MAX_DEVICES = 64
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               cfg_we_i,
  input  logic [cvfs_pkg::CFG_IDX_W-1:0]     cfg_index_i,
  input  logic [cvfs_pkg::CFG_DAT_W-1:0]     cfg_data_i,
  input  logic                               in_valid_i,
  output logic                               in_ready_o,
  input  logic [cvfs_pkg::BYTE_W-1:0]        rx_byte_i,
  input  logic                               first_of_read_i,
  output logic                               tok_valid_o,
  input  logic                               tok_ready_i,
  output cvfs_pkg::cvfs_tok_t                tok_o
);
  import cvfs_pkg::*;

  localparam logic [CELLS_W-1:0] MaxCells = CELLS_W'(MAX_CELLS);
  localparam logic [NDEV_W-1:0]  MaxDevs  = NDEV_W'(MAX_DEVICES);

  logic [CELLS_W-1:0] cells_q;
  logic [NDEV_W-1:0]  ndev_q;

  logic [POS_W-1:0]   pos_q, pos_c, pos_d;
  logic [DEV_W-1:0]   dev_q, dev_c, dev_d;
  logic [POS_W-1:0]   exp_q, exp_c, exp_d;
  logic [BYTE_W-1:0]  hold_q, hold_c, hold_d;
  logic               fin_q, fin_c, fin_d;

  logic [CELLS_W-1:0] cells_eff;
  logic [NDEV_W-1:0]  ndev_eff;
  logic [POS_W-1:0]   flen;
  logic [POS_W-1:0]   dpos;
  logic [8:0]         half_len;
  logic [CELLS_W-1:0] samples;
  logic               dev_last;
  logic               accept;
  cvfs_tok_t          tok_d;
  logic               tok_valid_q;
  cvfs_tok_t          tok_q;

  // Configuration writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cells_q <= CELLS_RESET;
      ndev_q  <= NDEV_RESET;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        CFG_CELLS_PER_DEVICE: cells_q <= cfg_data_i[CELLS_W-1:0];
        CFG_NUM_DEVICES:      ndev_q  <= cfg_data_i[NDEV_W-1:0];
        default:              ;
      endcase
    end
  end

  // Saturate the registers to their legal ranges
  always_comb begin
    if (cells_q < CELLS_MIN)     cells_eff = CELLS_MIN;
    else if (cells_q > MaxCells) cells_eff = MaxCells;
    else                         cells_eff = cells_q;
    if (ndev_q < NDEV_MIN)       ndev_eff = NDEV_MIN;
    else if (ndev_q > MaxDevs)   ndev_eff = MaxDevs;
    else                         ndev_eff = ndev_q;
  end

  assign flen       = FRAME_OVERHEAD + {cells_eff, 1'b0};
  assign in_ready_o = !tok_valid_q || tok_ready_i;
  assign accept     = in_valid_i && in_ready_o;

  // Frame walk for the byte at the input
  always_comb begin
    pos_c  = first_of_read_i ? '0 : pos_q;
    dev_c  = first_of_read_i ? '0 : dev_q;
    exp_c  = first_of_read_i ? '0 : exp_q;
    hold_c = first_of_read_i ? '0 : hold_q;
    fin_c  = first_of_read_i ? 1'b0 : fin_q;

    pos_d  = pos_c;
    dev_d  = dev_c;
    exp_d  = exp_c;
    hold_d = hold_c;
    fin_d  = fin_c;

    dpos     = pos_c - HEADER_BYTES;
    dev_last = ({1'b0, dev_c} + NDEV_W'(1)) >= ndev_eff;
    half_len = ({1'b0, rx_byte_i} + 9'd2) >> 1;
    if (half_len > {4'b0, cells_eff}) samples = cells_eff;
    else                              samples = half_len[CELLS_W-1:0];

    tok_d.sample = 1'b0;
    tok_d.clear  = first_of_read_i;
    tok_d.dev    = dev_c;
    tok_d.idx    = dpos[IDX_W:1];
    tok_d.last   = 1'b0;
    tok_d.raw    = {hold_c, rx_byte_i};

    if (!fin_c) begin
      // Length byte sets the data byte count, other bytes may carry samples
      if (pos_c == '0) begin
        exp_d = {samples, 1'b0};
      end else if (pos_c >= HEADER_BYTES && dpos < exp_c) begin
        if (!dpos[0]) begin
          hold_d = rx_byte_i;
        end else begin
          tok_d.sample = 1'b1;
          tok_d.last   = (dpos + POS_W'(1) == exp_c) && dev_last;
        end
      end

      // Advance to the next frame or finish the read
      if (({1'b0, pos_c} + 7'd1) >= {1'b0, flen}) begin
        pos_d = '0;
        if (dev_last) fin_d = 1'b1;
        else          dev_d = dev_c + DEV_W'(1);
      end else begin
        pos_d = pos_c + POS_W'(1);
      end
    end
  end

  // Frame state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q  <= '0;
      dev_q  <= '0;
      exp_q  <= '0;
      hold_q <= '0;
      fin_q  <= 1'b0;
    end else if (accept) begin
      pos_q  <= pos_d;
      dev_q  <= dev_d;
      exp_q  <= exp_d;
      hold_q <= hold_d;
      fin_q  <= fin_d;
    end
  end

  // Token register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tok_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      tok_valid_q <= accept && (tok_d.sample || tok_d.clear);
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      tok_q <= tok_d;
    end
  end

  assign tok_valid_o = tok_valid_q;
  assign tok_o       = tok_q;

endmodule

// ----- hdl/cvfs_scale.sv -----
// ----------------------------------------------------------------------------
// cvfs_scale
// Multiplies each raw sample by the fixed voltage scale in its own stage.
// ----------------------------------------------------------------------------
module cvfs_scale (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                tok_valid_i,
  output logic                tok_ready_o,
  input  cvfs_pkg::cvfs_tok_t tok_i,
  output logic                scl_valid_o,
  input  logic                scl_ready_i,
  output cvfs_pkg::cvfs_scl_t scl_o
);
  import cvfs_pkg::*;

  logic      valid_q;
  cvfs_scl_t scl_q;
  cvfs_scl_t scl_d;
  logic      load;

  assign tok_ready_o = !valid_q || scl_ready_i;
  assign load        = tok_valid_i && tok_ready_o;

  // Scale the sample; 65535 * 19073 still fits in 31 bits
  always_comb begin
    scl_d.sample = tok_i.sample;
    scl_d.clear  = tok_i.clear;
    scl_d.dev    = tok_i.dev;
    scl_d.idx    = tok_i.idx;
    scl_d.last   = tok_i.last;
    scl_d.volt   = VOLT_W'(tok_i.raw) * VOLT_W'(VOLT_SCALE);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (tok_ready_o) begin
      valid_q <= tok_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      scl_q <= scl_d;
    end
  end

  assign scl_valid_o = valid_q;
  assign scl_o       = scl_q;

endmodule

// ----- hdl/cvfs_stats.sv -----
// ----------------------------------------------------------------------------
// cvfs_stats
// Keeps the running total, maximum and minimum and holds the result register.
// ----------------------------------------------------------------------------
module cvfs_stats (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              scl_valid_i,
  output logic                              scl_ready_o,
  input  cvfs_pkg::cvfs_scl_t               scl_i,
  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  output logic [cvfs_pkg::DEV_W-1:0]        device_index_o,
  output logic [cvfs_pkg::IDX_W-1:0]        cell_index_o,
  output logic [cvfs_pkg::VOLT_W-1:0]       cell_voltage_o,
  output logic [cvfs_pkg::TOTAL_W-1:0]      total_voltage_o,
  output logic [cvfs_pkg::VOLT_W-1:0]       highest_voltage_o,
  output logic [cvfs_pkg::VOLT_W-1:0]       lowest_voltage_o,
  output logic                              last_cell_o
);
  import cvfs_pkg::*;

  logic                out_valid_q;
  logic [DEV_W-1:0]    dev_q;
  logic [IDX_W-1:0]    idx_q;
  logic [VOLT_W-1:0]   volt_q;
  logic                last_q;
  logic [TOTAL_W-1:0]  total_q, total_d, total_c;
  logic [VOLT_W-1:0]   max_q, max_d, max_c;
  logic [VOLT_W-1:0]   min_q, min_d, min_c;
  logic                load;

  assign scl_ready_o = !out_valid_q || !out_stall_i;
  assign load        = scl_valid_i && scl_ready_o;

  // Clear first on a new read, then fold in the sample
  always_comb begin
    total_c = scl_i.clear ? '0 : total_q;
    max_c   = scl_i.clear ? '0 : max_q;
    min_c   = scl_i.clear ? '0 : min_q;
    total_d = total_c;
    max_d   = max_c;
    min_d   = min_c;
    if (scl_i.sample) begin
      total_d = total_c + TOTAL_W'(scl_i.volt);
      if (max_c < scl_i.volt) max_d = scl_i.volt;
      if (min_c == '0 || min_c > scl_i.volt) min_d = scl_i.volt;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      total_q     <= '0;
      max_q       <= '0;
      min_q       <= '0;
    end else if (scl_ready_o) begin
      out_valid_q <= scl_valid_i && scl_i.sample;
      if (scl_valid_i) begin
        total_q <= total_d;
        max_q   <= max_d;
        min_q   <= min_d;
      end
    end
  end

  // Result payload
  always_ff @(posedge clk_i) begin
    if (load && scl_i.sample) begin
      dev_q  <= scl_i.dev;
      idx_q  <= scl_i.idx;
      volt_q <= scl_i.volt;
      last_q <= scl_i.last;
    end
  end

  assign out_valid_o       = out_valid_q;
  assign device_index_o    = dev_q;
  assign cell_index_o      = idx_q;
  assign cell_voltage_o    = volt_q;
  assign total_voltage_o   = total_q;
  assign highest_voltage_o = max_q;
  assign lowest_voltage_o  = min_q;
  assign last_cell_o       = last_q;

  a_volt_le_max: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> volt_q <= max_q)
    else $error("cell voltage above running maximum");

  a_min_le_max: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> min_q <= max_q)
    else $error("running minimum above running maximum");

  a_min_le_volt: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && min_q != '0) |-> min_q <= volt_q)
    else $error("running minimum above current cell voltage");

  a_total_ge_volt: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> total_q >= TOTAL_W'(volt_q))
    else $error("running total below current cell voltage");

endmodule

// ----- hdl/cell_voltage_frame_stats.sv -----
// ----------------------------------------------------------------------------
// cell_voltage_frame_stats
// Cell voltage extraction and running total, maximum and minimum over the
// bytes of a stacked read response.
// ----------------------------------------------------------------------------
// One response byte is taken per transfer and a new byte can follow in every
// cycle while in_stall_o is low. A sample's result is registered in turn
// by the frame parser at the transfer of its low byte, by the 16 x 15 bit
// scale multiplier, and by the statistics update, which with its 41-bit add
// and 31-bit compares loads the output register. A stalled output holds
// every stage. Header, CRC and trailing bytes give no result. A byte with
// first_of_read set starts a new response and clears the statistics; after
// reset the block behaves as if a response had just begun. The lowest
// voltage reads zero until a nonzero sample has been seen.
// ----------------------------------------------------------------------------
module cell_voltage_frame_stats #(
  parameter int unsigned MAX_CELLS   = 16,
  parameter int unsigned MAX_DEVICES = 64
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [cvfs_pkg::CFG_IDX_W-1:0]    cfg_index_i,
  input  logic [cvfs_pkg::CFG_DAT_W-1:0]    cfg_data_i,
  input  logic                              in_valid_i,
  output logic                              in_stall_o,
  input  logic [cvfs_pkg::BYTE_W-1:0]       rx_byte_i,
  input  logic                              first_of_read_i,
  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  output logic [cvfs_pkg::DEV_W-1:0]        device_index_o,
  output logic [cvfs_pkg::IDX_W-1:0]        cell_index_o,
  output logic [cvfs_pkg::VOLT_W-1:0]       cell_voltage_o,
  output logic [cvfs_pkg::TOTAL_W-1:0]      total_voltage_o,
  output logic [cvfs_pkg::VOLT_W-1:0]       highest_voltage_o,
  output logic [cvfs_pkg::VOLT_W-1:0]       lowest_voltage_o,
  output logic                              last_cell_o
);
  import cvfs_pkg::*;

  logic      in_ready;
  logic      tok_valid, tok_ready;
  cvfs_tok_t tok;
  logic      scl_valid, scl_ready;
  cvfs_scl_t scl;

  assign in_stall_o = !in_ready;

  // Frame parser and configuration
  cvfs_parser #(
    .MAX_CELLS   (MAX_CELLS),
    .MAX_DEVICES (MAX_DEVICES)
  ) u_parser (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_index_i     (cfg_index_i),
    .cfg_data_i      (cfg_data_i),
    .in_valid_i      (in_valid_i),
    .in_ready_o      (in_ready),
    .rx_byte_i       (rx_byte_i),
    .first_of_read_i (first_of_read_i),
    .tok_valid_o     (tok_valid),
    .tok_ready_i     (tok_ready),
    .tok_o           (tok)
  );

  // Voltage scaling
  cvfs_scale u_scale (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .tok_valid_i (tok_valid),
    .tok_ready_o (tok_ready),
    .tok_i       (tok),
    .scl_valid_o (scl_valid),
    .scl_ready_i (scl_ready),
    .scl_o       (scl)
  );

  // Running statistics and result register
  cvfs_stats u_stats (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .scl_valid_i       (scl_valid),
    .scl_ready_o       (scl_ready),
    .scl_i             (scl),
    .out_valid_o       (out_valid_o),
    .out_stall_i       (out_stall_i),
    .device_index_o    (device_index_o),
    .cell_index_o      (cell_index_o),
    .cell_voltage_o    (cell_voltage_o),
    .total_voltage_o   (total_voltage_o),
    .highest_voltage_o (highest_voltage_o),
    .lowest_voltage_o  (lowest_voltage_o),
    .last_cell_o       (last_cell_o)
  );

endmodule

// ----- tb/tb_cell_voltage_frame_stats.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_cell_voltage_frame_stats
// Self-checking bench for the cell voltage frame statistics block. Response
// byte streams (full frames, cut frames, stray bytes) are driven through the
// valid/stall input under changing cell and device counts. A software copy
// of the frame parser and statistics predicts every sample result, and each
// output transfer is checked field by field in order of arrival.
// ----------------------------------------------------------------------------
module tb_cell_voltage_frame_stats;
  import cvfs_pkg::*;

  localparam int unsigned CLK_PERIOD   = 20;
  localparam int unsigned MAX_CELLS    = 16;
  localparam int unsigned MAX_DEVICES  = 64;
  localparam int unsigned N_PHASES     = 12;
  localparam int unsigned PHASE_BYTES  = 48;
  localparam int unsigned HOLD_PHASE   = 9;
  localparam int unsigned LONG_HOLD    = 400;
  localparam int unsigned DRAIN_CYCLES = 8;
  localparam int unsigned STUCK_LIMIT  = 4000;
  localparam int unsigned REPORT_MAX   = 10;
  localparam int unsigned N_DIRECTED   = 25;

  typedef struct {
    logic [BYTE_W-1:0] b;
    logic              first_of_read;
  } stream_byte_t;

  typedef struct {
    logic [DEV_W-1:0]   dev;
    logic [IDX_W-1:0]   idx;
    logic [VOLT_W-1:0]  volt;
    logic [TOTAL_W-1:0] total;
    logic [VOLT_W-1:0]  high;
    logic [VOLT_W-1:0]  low;
    logic               last;
  } cell_sample_t;

  // DUT inputs, all known from time zero
  logic                 clk_i         = 1'b0;
  logic                 rst_ni        = 1'b0;
  logic                 cfg_we        = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index     = CFG_CELLS_PER_DEVICE;
  logic [CFG_DAT_W-1:0] cfg_data      = '0;
  logic                 in_valid      = 1'b0;
  logic [BYTE_W-1:0]    rx_byte       = '0;
  logic                 first_of_read = 1'b0;
  logic                 out_stall     = 1'b0;

  // DUT outputs
  logic                 in_stall;
  logic                 out_valid;
  logic [DEV_W-1:0]     device_index;
  logic [IDX_W-1:0]     cell_index;
  logic [VOLT_W-1:0]    cell_voltage;
  logic [TOTAL_W-1:0]   total_voltage;
  logic [VOLT_W-1:0]    highest_voltage;
  logic [VOLT_W-1:0]    lowest_voltage;
  logic                 last_cell;

  // Stimulus and expected results
  stream_byte_t  byte_pending[$];
  stream_byte_t  next_byte;
  cell_sample_t  sample_expected[$];
  int unsigned   mismatch_cnt  = 0;
  int unsigned   stuck_cycles  = 0;
  int unsigned   send_idle_pct = 0;
  int unsigned   recv_idle_pct = 0;
  bit            hold_req      = 1'b0;
  bit            hold_taken    = 1'b0;
  int unsigned   hold_left     = 0;

  // Predictor copy of registers and parser state
  logic [CELLS_W-1:0] model_cells = CELLS_RESET;
  logic [NDEV_W-1:0]  model_ndev  = NDEV_RESET;
  logic [POS_W-1:0]   frame_pos;
  logic [DEV_W-1:0]   dev_cnt;
  logic [POS_W-1:0]   bytes_due;
  logic [BYTE_W-1:0]  hi_byte;
  logic [TOTAL_W-1:0] sum_volt;
  logic [VOLT_W-1:0]  max_volt;
  logic [VOLT_W-1:0]  min_volt;
  bit                 read_done;

  // Directed opening: a frame sent without first_of_read right after reset,
  // length byte above the cap, zero / full-scale / mid samples, a stray byte
  // after the last frame, then a new read with a one-sample length byte
  logic [BYTE_W-1:0] directed_bytes [N_DIRECTED] = '{
    8'hFF, 8'h3C, 8'h05, 8'h68, 8'h00, 8'h00, 8'hFF, 8'hFF, 8'h00, 8'h01,
    8'h80, 8'h00, 8'h7F, 8'hFF, 8'h00, 8'hFF, 8'h5A, 8'hA5, 8'h81,
    8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h07
  };

  int unsigned phase_cells [N_PHASES] = '{16, 6, 31, 0, 5, 17, 11, 16, 6, 9, 31, 7};
  int unsigned phase_ndev  [N_PHASES] = '{1, 2, 3, 4, 0, 2, 1, 64, 2, 127, 65, 3};

  cell_voltage_frame_stats #(
    .MAX_CELLS   (MAX_CELLS),
    .MAX_DEVICES (MAX_DEVICES)
  ) uut (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cfg_we_i          (cfg_we),
    .cfg_index_i       (cfg_index),
    .cfg_data_i        (cfg_data),
    .in_valid_i        (in_valid),
    .in_stall_o        (in_stall),
    .rx_byte_i         (rx_byte),
    .first_of_read_i   (first_of_read),
    .out_valid_o       (out_valid),
    .out_stall_i       (out_stall),
    .device_index_o    (device_index),
    .cell_index_o      (cell_index),
    .cell_voltage_o    (cell_voltage),
    .total_voltage_o   (total_voltage),
    .highest_voltage_o (highest_voltage),
    .lowest_voltage_o  (lowest_voltage),
    .last_cell_o       (last_cell)
  );

  always #(CLK_PERIOD / 2) clk_i = ~clk_i;

  function automatic int unsigned sat_cells(input logic [CELLS_W-1:0] c);
    if (c < CELLS_MIN) return 32'(CELLS_MIN);
    if (32'(c) > MAX_CELLS) return MAX_CELLS;
    return 32'(c);
  endfunction

  function automatic int unsigned sat_ndev(input logic [NDEV_W-1:0] n);
    if (n < NDEV_MIN) return 32'(NDEV_MIN);
    if (32'(n) > MAX_DEVICES) return MAX_DEVICES;
    return 32'(n);
  endfunction

  function automatic void clear_stats();
    frame_pos = '0;
    dev_cnt   = '0;
    bytes_due = '0;
    hi_byte   = '0;
    sum_volt  = '0;
    max_volt  = '0;
    min_volt  = '0;
    read_done = 1'b0;
  endfunction

  // Advance the frame parser by one byte and queue the sample it completes
  function automatic void predict_byte(input logic [BYTE_W-1:0] b, input logic new_read);
    int unsigned  cells, flen, ndev, cnt, d, prod;
    cell_sample_t s;
    if (new_read) clear_stats();
    if (read_done) return;
    cells = sat_cells(model_cells);
    flen  = 32'(FRAME_OVERHEAD) + 2 * cells;
    ndev  = sat_ndev(model_ndev);
    if (frame_pos == '0) begin
      // sample count from the length byte, rounded up and capped
      cnt = (32'(b) + 2) / 2;
      if (cnt > cells) cnt = cells;
      bytes_due = POS_W'(2 * cnt);
    end else if (frame_pos >= HEADER_BYTES) begin
      d = 32'(frame_pos - HEADER_BYTES);
      if (d < 32'(bytes_due)) begin
        if (d % 2 == 0) begin
          hi_byte = b;
        end else begin
          prod = 32'({hi_byte, b}) * 32'(VOLT_SCALE);
          s.volt = prod[VOLT_W-1:0];
          sum_volt = sum_volt + TOTAL_W'(s.volt);
          if (max_volt < s.volt) max_volt = s.volt;
          // zero stands for an unset minimum
          if (min_volt == '0 || min_volt > s.volt) min_volt = s.volt;
          s.dev   = dev_cnt;
          s.idx   = IDX_W'(d / 2);
          s.total = sum_volt;
          s.high  = max_volt;
          s.low   = min_volt;
          s.last  = (d + 1 == 32'(bytes_due)) && (32'(dev_cnt) + 1 >= ndev);
          sample_expected.push_back(s);
        end
      end
    end
    // Step to the next byte or frame; stop after the last frame
    if (32'(frame_pos) + 1 >= flen) begin
      frame_pos = '0;
      if (32'(dev_cnt) + 1 >= ndev) read_done = 1'b1;
      else dev_cnt = dev_cnt + DEV_W'(1);
    end else begin
      frame_pos = frame_pos + POS_W'(1);
    end
  endfunction

  // Compare one output transfer with the oldest expected sample
  function automatic void check_sample();
    cell_sample_t want;
    if (sample_expected.size() == 0) begin
      mismatch_cnt++;
      if (mismatch_cnt <= REPORT_MAX)
        $display("unexpected result: dev %0d cell %0d volt %0d total %0d",
                 device_index, cell_index, cell_voltage, total_voltage);
      return;
    end
    want = sample_expected.pop_front();
    if (device_index !== want.dev || cell_index !== want.idx ||
        cell_voltage !== want.volt || total_voltage !== want.total ||
        highest_voltage !== want.high || lowest_voltage !== want.low ||
        last_cell !== want.last) begin
      mismatch_cnt++;
      if (mismatch_cnt <= REPORT_MAX) begin
        $display({"result mismatch: expected dev %0d cell %0d volt %0d total %0d",
                  " high %0d low %0d last %0b"},
                 want.dev, want.idx, want.volt, want.total, want.high, want.low,
                 want.last);
        $display({"                 actual   dev %0d cell %0d volt %0d total %0d",
                  " high %0d low %0d last %0b"},
                 device_index, cell_index, cell_voltage, total_voltage,
                 highest_voltage, lowest_voltage, last_cell);
      end
    end
  endfunction

  function automatic void push_byte(input logic [BYTE_W-1:0] b, input logic new_read);
    stream_byte_t e;
    e.b = b;
    e.first_of_read = new_read;
    byte_pending.push_back(e);
  endfunction

  // Queue one response of ndev frames with random content, possibly cut short
  function automatic int unsigned queue_response(input int unsigned cells,
                                                 input int unsigned ndev,
                                                 input int unsigned room,
                                                 input bit may_cut);
    int unsigned       flen, full, cut, pos, r;
    logic [BYTE_W-1:0] b;
    logic [RAW_W-1:0]  smp;
    flen = 32'(FRAME_OVERHEAD) + 2 * cells;
    full = flen * ndev;
    cut  = full;
    smp  = '0;
    if (may_cut && $urandom_range(99) < 15) cut = $urandom_range(full, 1);
    if (cut > room) cut = room;
    for (int unsigned n = 0; n < cut; n++) begin
      pos = n % flen;
      if (pos == 0) begin
        // mostly the full count, sometimes short or over the cap
        r = $urandom_range(99);
        if (r < 70) b = BYTE_W'(2 * cells - 1);
        else if (r < 85) b = BYTE_W'($urandom_range(255));
        else b = BYTE_W'($urandom_range(2 * cells - 1));
      end else if (pos >= 32'(HEADER_BYTES) && pos < 32'(HEADER_BYTES) + 2 * cells) begin
        if ((pos - 32'(HEADER_BYTES)) % 2 == 0) begin
          case ($urandom_range(7))
            0:       smp = '0;
            1:       smp = '1;
            2:       smp = RAW_W'($urandom_range(255));
            default: smp = RAW_W'($urandom_range(65535));
          endcase
          b = smp[15:8];
        end else begin
          b = smp[7:0];
        end
      end else begin
        b = BYTE_W'($urandom_range(255));
      end
      push_byte(b, n == 0);
    end
    return cut;
  endfunction

  // Driver: offer the next pending byte, hold it while stalled
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid      <= 1'b0;
      rx_byte       <= '0;
      first_of_read <= 1'b0;
    end else if (!in_valid || !in_stall) begin
      if (byte_pending.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        next_byte     = byte_pending.pop_front();
        in_valid      <= 1'b1;
        rx_byte       <= next_byte.b;
        first_of_read <= next_byte.first_of_read;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Receiver: random stall, plus one long hold-off on request
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_stall  <= 1'b0;
      hold_taken <= 1'b0;
      hold_left  <= 0;
    end else if (hold_req && !hold_taken) begin
      hold_taken <= 1'b1;
      hold_left  <= LONG_HOLD;
      out_stall  <= 1'b1;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(99) < recv_idle_pct);
    end
  end

  // Monitor: check output transfers, predict from input transfers
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clear_stats();
    end else begin
      if (out_valid && !out_stall) check_sample();
      if (in_valid && !in_stall) predict_byte(rx_byte, first_of_read);
    end
  end

  // Watchdog: give up when no transfer happens for too long
  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid && !in_stall) || (out_valid && !out_stall))
      stuck_cycles <= 0;
    else
      stuck_cycles <= stuck_cycles + 1;
    if (stuck_cycles >= STUCK_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  // Wait until every byte is in and every result is out, then let the pipe empty
  task automatic wait_drained();
    do @(negedge clk_i);
    while (byte_pending.size() != 0 || in_valid || sample_expected.size() != 0);
    repeat (DRAIN_CYCLES) @(negedge clk_i);
  endtask

  task automatic set_config(input int unsigned cells, input int unsigned ndev);
    @(posedge clk_i);
    cfg_we    <= 1'b1;
    cfg_index <= CFG_CELLS_PER_DEVICE;
    cfg_data  <= CFG_DAT_W'(cells);
    @(posedge clk_i);
    cfg_index <= CFG_NUM_DEVICES;
    cfg_data  <= CFG_DAT_W'(ndev);
    @(posedge clk_i);
    cfg_we      <= 1'b0;
    model_cells = CELLS_W'(cells);
    model_ndev  = NDEV_W'(ndev);
  endtask

  // Stimulus sequence
  initial begin
    int unsigned queued;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;

    // directed opening with six cells and a single device
    send_idle_pct = 28;
    recv_idle_pct = 75;
    set_config(32'(CELLS_MIN), 1);
    @(negedge clk_i);
    for (int unsigned i = 0; i < N_DIRECTED; i++) push_byte(directed_bytes[i], i == 19);

    // random phases, each under its own register setting
    for (int unsigned ph = 0; ph < N_PHASES; ph++) begin
      wait_drained();
      if (ph < 4) begin
        send_idle_pct = 28;
        recv_idle_pct = 75;
      end else if (ph < 8) begin
        send_idle_pct = 75;
        recv_idle_pct = 28;
      end else begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      set_config(phase_cells[ph], phase_ndev[ph]);
      @(negedge clk_i);
      if (ph == HOLD_PHASE) hold_req = 1'b1;
      queued = 0;
      while (queued < PHASE_BYTES) begin
        if ($urandom_range(99) < 15) begin
          // noise: stray bytes, now and then a bare first_of_read
          for (int unsigned k = $urandom_range(6, 1); k > 0; k--) begin
            push_byte(BYTE_W'($urandom_range(255)), $urandom_range(3) == 0);
            queued++;
          end
        end else begin
          queued += queue_response(sat_cells(CELLS_W'(phase_cells[ph])),
                                   sat_ndev(NDEV_W'(phase_ndev[ph])),
                                   PHASE_BYTES - queued, 1'b1);
        end
      end
    end

    // one complete response across the largest device count
    wait_drained();
    set_config(32'(CELLS_MIN), MAX_DEVICES);
    @(negedge clk_i);
    queued = queue_response(32'(CELLS_MIN), MAX_DEVICES,
                            32'(FRAME_OVERHEAD) * MAX_DEVICES * 8, 1'b0);

    wait_drained();
    if (mismatch_cnt == 0 && sample_expected.size() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
